/* src/pfs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package pfs_pkg;

  localparam int REG_SLOTS  = 16;
  localparam int SLOT_W     = $clog2(REG_SLOTS);
  localparam int FRAME_W    = 32;
  localparam int HALF_W     = 16;

  localparam logic [HALF_W-1:0] PUSH_MASK   = 16'hf0ff;
  localparam logic [HALF_W-1:0] PUSH_MATCH  = 16'h207f;
  localparam logic [7:0]        ADDI_OP     = 8'h4f;
  localparam logic [HALF_W-1:0] ADD3_OP     = 16'h8faf;
  localparam logic [7:0]        LD24_OP     = 8'he4;
  localparam logic [HALF_W-1:0] SUB_OP      = 16'h0f24;
  localparam logic [HALF_W-1:0] MVFP_OP     = 16'h1d8f;
  localparam logic [FRAME_W-1:0] PUSH_STEP  = 32'd4;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_HALF  = 1'b1;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(REG_SLOTS - 1);

  typedef struct packed {
    logic clear;
    logic push;
    logic addi;
    logic add3;
    logic ld_hi;
    logic ld_lo;
    logic ld_apply;
    logic set_fp;
  } pfs_cmd_t;

  typedef struct packed {
    logic is_push;
    logic is_addi;
    logic is_add3;
    logic is_ld24;
    logic is_mvfp;
    logic is_sub;
  } pfs_stat_t;

endpackage
`default_nettype wire

/* src/pfs_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
module pfs_datapath (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire pfs_pkg::pfs_cmd_t                 cmd,
  input  wire logic [pfs_pkg::HALF_W-1:0]        code_halfword,
  input  wire logic [pfs_pkg::SLOT_W-1:0]        rd_index,
  output pfs_pkg::pfs_stat_t                     stat,
  output logic [pfs_pkg::FRAME_W-1:0]            frame_size,
  output logic                                   uses_fp,
  output logic [pfs_pkg::FRAME_W-1:0]            slot_offset
);
  import pfs_pkg::*;

  logic [FRAME_W-1:0]   frame_total;
  logic [FRAME_W-1:0]   frame_total_next;
  logic [FRAME_W-1:0]   pushed_total;
  logic [FRAME_W-1:0]   slots [REG_SLOTS];
  logic [REG_SLOTS-1:0] slot_valid;
  logic                 fp_flag;
  logic [7:0]           pending_high_byte;
  logic [HALF_W-1:0]    pending_low_half;
  logic [SLOT_W-1:0]    push_index;
  logic [23:0]          ld_imm;

  assign push_index   = code_halfword[11:8];
  assign pushed_total = frame_total + PUSH_STEP;
  assign ld_imm       = {pending_high_byte, pending_low_half};

  always_comb begin
    stat.is_push = (code_halfword & PUSH_MASK) == PUSH_MATCH;
    stat.is_addi = code_halfword[15:8] == ADDI_OP;
    stat.is_add3 = code_halfword == ADD3_OP;
    stat.is_ld24 = code_halfword[15:8] == LD24_OP;
    stat.is_mvfp = code_halfword == MVFP_OP;
    stat.is_sub  = code_halfword == SUB_OP;
  end

  always_comb begin
    frame_total_next = frame_total;
    if (cmd.clear) begin
      frame_total_next = '0;
    end else if (cmd.push) begin
      frame_total_next = pushed_total;
    end else if (cmd.addi) begin
      frame_total_next = frame_total - {{(FRAME_W-8){code_halfword[7]}}, code_halfword[7:0]};
    end else if (cmd.add3) begin
      frame_total_next = frame_total - {{(FRAME_W-HALF_W){code_halfword[15]}}, code_halfword};
    end else if (cmd.ld_apply) begin
      frame_total_next = frame_total + {{(FRAME_W-24){ld_imm[23]}}, ld_imm};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_total       <= '0;
      slot_valid        <= '0;
      fp_flag           <= 1'b0;
      pending_high_byte <= '0;
      pending_low_half  <= '0;
    end else begin
      frame_total <= frame_total_next;
      if (cmd.clear) begin
        slot_valid        <= '0;
        fp_flag           <= 1'b0;
        pending_high_byte <= '0;
        pending_low_half  <= '0;
      end else begin
        if (cmd.push) begin
          slot_valid[push_index] <= 1'b1;
        end
        if (cmd.set_fp) begin
          fp_flag <= 1'b1;
        end
        if (cmd.ld_hi) begin
          pending_high_byte <= code_halfword[7:0];
        end
        if (cmd.ld_lo) begin
          pending_low_half <= code_halfword;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push && !cmd.clear) begin
      slots[push_index] <= pushed_total;
    end
  end

  assign frame_size  = frame_total;
  assign uses_fp     = fp_flag;
  assign slot_offset = slot_valid[rd_index] ? slots[rd_index] : '0;

endmodule
`default_nettype wire

/* src/pfs_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module pfs_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         req_type,
  input  wire logic                         in_range,
  input  wire pfs_pkg::pfs_stat_t           stat,
  output pfs_pkg::pfs_cmd_t                 cmd,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [pfs_pkg::SLOT_W-1:0]        slot_index,
  output logic                              slot_last
);
  import pfs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INSN,
    ST_ADD3,
    ST_LD_LO,
    ST_LD_SUB,
    ST_EMIT
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [SLOT_W-1:0] slot_cnt;
  logic              in_take;
  logic              out_take;

  assign in_ready   = state != ST_EMIT;
  assign in_take    = in_valid && in_ready;
  assign out_valid  = state == ST_EMIT;
  assign out_take   = out_valid && out_ready;
  assign slot_index = slot_cnt;
  assign slot_last  = slot_cnt == LAST_SLOT;

  always_comb begin
    cmd        = '0;
    state_next = state;
    if (in_take) begin
      if (req_type == REQ_START) begin
        cmd.clear  = 1'b1;
        state_next = ST_INSN;
      end else begin
        unique case (state)
          ST_INSN: begin
            if (!in_range) begin
              state_next = ST_EMIT;
            end else if (stat.is_push) begin
              cmd.push = 1'b1;
            end else if (stat.is_addi) begin
              cmd.addi = 1'b1;
            end else if (stat.is_add3) begin
              state_next = ST_ADD3;
            end else if (stat.is_ld24) begin
              cmd.ld_hi  = 1'b1;
              state_next = ST_LD_LO;
            end else begin
              cmd.set_fp = stat.is_mvfp;
              state_next = ST_EMIT;
            end
          end
          ST_ADD3: begin
            cmd.add3   = 1'b1;
            state_next = ST_INSN;
          end
          ST_LD_LO: begin
            cmd.ld_lo  = 1'b1;
            state_next = ST_LD_SUB;
          end
          ST_LD_SUB: begin
            cmd.ld_apply = stat.is_sub;
            state_next   = ST_EMIT;
          end
          default: begin
            state_next = state;
          end
        endcase
      end
    end else if (out_take && slot_last) begin
      state_next = ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      slot_cnt <= '0;
    end else begin
      state <= state_next;
      if (out_take) begin
        slot_cnt <= slot_last ? '0 : slot_cnt + 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* src/prologue_frame_size_scanner.sv */
`timescale 1ns / 1ps
`default_nettype none
// Prologue frame size scanner.
// Input beats on s_*: tuser carries the request kind (0 starts a scan and
// clears the frame size, save slots and frame-pointer flag; 1 delivers one
// code halfword). tdata carries the halfword and its in-range flag.
// Each input beat is decoded combinationally; s_tready stays high at one beat
// per cycle while a scan runs. When the scan ends (frame-pointer move, any
// other instruction, an instruction start out of range, or after a ld24
// lookahead) the block emits sixteen result beats on m_*, one per save
// slot, register 0 first, with m_tlast on the last. The dump is read out
// through the single slot read port; s_tready is low throughout it.
// The first result is offered the cycle after the ending beat is taken.
// A stalled m_tready holds the current slot beat unchanged.
// Halfwords sent with no scan active are taken and dropped.
// Reset leaves the block idle with all state cleared; no clearing pass.
module prologue_frame_size_scanner (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,  // code_halfword[15:0], in_range[16], zero[23:17]
  input  wire logic        s_tuser,  // req_type[0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [71:0]      m_tdata,  // frame_size[31:0], uses_fp[32], slot_index[36:33],
                                     // slot_offset[68:37], zero[71:69]
  output logic             m_tlast   // slot_last
);
  import pfs_pkg::*;

  pfs_cmd_t           cmd;
  pfs_stat_t          stat;
  logic [SLOT_W-1:0]  slot_index;
  logic [FRAME_W-1:0] frame_size;
  logic [FRAME_W-1:0] slot_offset;
  logic               uses_fp;

  pfs_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .req_type   (s_tuser),
    .in_range   (s_tdata[16]),
    .stat       (stat),
    .cmd        (cmd),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .slot_index (slot_index),
    .slot_last  (m_tlast)
  );

  pfs_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .code_halfword (s_tdata[15:0]),
    .rd_index      (slot_index),
    .stat          (stat),
    .frame_size    (frame_size),
    .uses_fp       (uses_fp),
    .slot_offset   (slot_offset)
  );

  assign m_tdata = {3'b000, slot_offset, slot_index, uses_fp, frame_size};

endmodule
`default_nettype wire

/* sim/pfs_slot_checker.sv */
`timescale 1ns / 1ps
module pfs_slot_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,
  input  logic        s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [71:0] m_tdata,
  input  logic        m_tlast,
  output int          fail_count,
  output int          slots_owed
);
  import pfs_pkg::*;

  typedef enum logic [2:0] {
    SCAN_IDLE,
    SCAN_INSN,
    SCAN_ADD3_IMM,
    SCAN_LD24_LO,
    SCAN_LD24_SUB
  } scan_phase_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_size;
    logic               uses_fp;
    logic [SLOT_W-1:0]  slot_index;
    logic [FRAME_W-1:0] slot_offset;
    logic               slot_last;
  } slot_beat_t;

  logic [FRAME_W-1:0] frame_total;
  logic [FRAME_W-1:0] save_offset [REG_SLOTS];
  logic               fp_seen;
  scan_phase_t        phase;
  logic [7:0]         ld24_hi;
  logic [HALF_W-1:0]  ld24_lo;
  slot_beat_t         slot_dump_q [$];

  initial begin
    fail_count = 0;
    slots_owed = 0;
  end

  task automatic clear_scan();
    frame_total = '0;
    for (int k = 0; k < REG_SLOTS; k++) save_offset[k] = '0;
    fp_seen = 1'b0;
    phase   = SCAN_IDLE;
    ld24_hi = '0;
    ld24_lo = '0;
  endtask

  task automatic queue_slot_dump();
    slot_beat_t b;
    for (int k = 0; k < REG_SLOTS; k++) begin
      b.frame_size  = frame_total;
      b.uses_fp     = fp_seen;
      b.slot_index  = SLOT_W'(k);
      b.slot_offset = save_offset[k];
      b.slot_last   = (k == REG_SLOTS - 1);
      slot_dump_q.push_back(b);
    end
    phase = SCAN_IDLE;
  endtask

  task automatic scan_halfword(input logic req, input logic [HALF_W-1:0] h,
                               input logic in_range);
    if (req == REQ_START) begin
      clear_scan();
      phase = SCAN_INSN;
    end else begin
      case (phase)
        SCAN_INSN: begin
          if (!in_range) begin
            queue_slot_dump();
          end else if ((h & PUSH_MASK) == PUSH_MATCH) begin
            frame_total = frame_total + PUSH_STEP;
            save_offset[h[11:8]] = frame_total;
          end else if (h[15:8] == ADDI_OP) begin
            frame_total = frame_total - {{24{h[7]}}, h[7:0]};
          end else if (h == ADD3_OP) begin
            phase = SCAN_ADD3_IMM;
          end else if (h[15:8] == LD24_OP) begin
            ld24_hi = h[7:0];
            phase   = SCAN_LD24_LO;
          end else begin
            if (h == MVFP_OP) fp_seen = 1'b1;
            queue_slot_dump();
          end
        end
        SCAN_ADD3_IMM: begin
          frame_total = frame_total - {{16{h[15]}}, h};
          phase = SCAN_INSN;
        end
        SCAN_LD24_LO: begin
          ld24_lo = h;
          phase   = SCAN_LD24_SUB;
        end
        SCAN_LD24_SUB: begin
          if (h == SUB_OP) frame_total = frame_total + {{8{ld24_hi[7]}}, ld24_hi, ld24_lo};
          queue_slot_dump();
        end
        default: ;
      endcase
    end
  endtask

  task automatic report_mismatch(input string what, input logic [FRAME_W-1:0] got,
                                 input logic [FRAME_W-1:0] want);
    $display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    slot_beat_t want;
    if (rst) begin
      clear_scan();
      slot_dump_q.delete();
    end else begin
      if (s_tvalid && s_tready) scan_halfword(s_tuser, s_tdata[15:0], s_tdata[16]);
      if (m_tvalid && m_tready) begin
        if (slot_dump_q.size() == 0) begin
          report_mismatch("unexpected slot beat", m_tdata[31:0], '0);
        end else begin
          want = slot_dump_q.pop_front();
          if (m_tdata[31:0] !== want.frame_size)
            report_mismatch("frame_size", m_tdata[31:0], want.frame_size);
          if (m_tdata[32] !== want.uses_fp)
            report_mismatch("uses_fp", 32'(m_tdata[32]), 32'(want.uses_fp));
          if (m_tdata[36:33] !== want.slot_index)
            report_mismatch("slot_index", 32'(m_tdata[36:33]), 32'(want.slot_index));
          if (m_tdata[68:37] !== want.slot_offset)
            report_mismatch("slot_offset", m_tdata[68:37], want.slot_offset);
          if (m_tlast !== want.slot_last)
            report_mismatch("slot_last", 32'(m_tlast), 32'(want.slot_last));
        end
      end
    end
    slots_owed = slot_dump_q.size();
  end

endmodule

/* sim/prologue_frame_size_scanner_tb.sv */
`timescale 1ns / 1ps
module prologue_frame_size_scanner_tb;
  import pfs_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_BEATS = 72;
  localparam int HOLD_CYCLES = 300;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [71:0] m_tdata;
  logic        m_tlast;

  int fail_count;
  int slots_owed;
  int cycle_count = 0;
  int burst_left = 0;
  int beats_sent = 0;
  int hold_asks = 0;
  int holds_seen = 0;
  int hold_left = 0;
  int ready_mode = 0;
  int mode_left = 0;
  int ready_tick = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  prologue_frame_size_scanner dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  pfs_slot_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .fail_count (fail_count),
    .slots_owed (slots_owed)
  );

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_asks != holds_seen) begin
        holds_seen = hold_asks;
        hold_left  = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(8, 64);
      end
      mode_left--;
      ready_tick++;
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        case (ready_mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= (ready_tick % 4 == 0);
          default: m_tready <= ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  // call at a falling edge; returns at the falling edge after the beat is taken
  task automatic send_beat(input logic req, input logic [HALF_W-1:0] half,
                           input logic in_range);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= {7'b0, in_range, half};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    beats_sent++;
  endtask

  task automatic start_scan();
    send_beat(REQ_START, 16'($urandom), 1'($urandom_range(0, 1)));
  endtask

  task automatic send_half(input logic [HALF_W-1:0] half, input logic in_range);
    send_beat(REQ_HALF, half, in_range);
  endtask

  task automatic wait_for_slots();
    s_tvalid <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (slots_owed != 0);
  endtask

  task automatic random_scan();
    int n;
    int kind;
    if ($urandom_range(0, 9) == 0) send_half(16'($urandom), 1'($urandom_range(0, 1)));
    start_scan();
    n = $urandom_range(0, 8);
    repeat (n) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2: send_half(PUSH_MATCH | {4'($urandom), 8'h00}, 1'b1);
        3, 4: send_half({ADDI_OP, 8'($urandom)}, 1'b1);
        5, 6: begin
          send_half(ADD3_OP, 1'b1);
          send_half(16'($urandom), 1'($urandom_range(0, 1)));
        end
        7: send_half(PUSH_MATCH | {4'($urandom), 8'h00}, 1'b1);
        8: if ($urandom_range(0, 2) == 0) start_scan();
        default: send_half(16'($urandom), 1'($urandom_range(0, 1)));
      endcase
    end
    kind = $urandom_range(0, 5);
    case (kind)
      0: send_half(MVFP_OP, 1'b1);
      1: send_half(16'($urandom), 1'b0);
      2, 3: begin
        send_half({LD24_OP, 8'($urandom)}, 1'b1);
        send_half(16'($urandom), 1'($urandom_range(0, 1)));
        send_half((kind == 2) ? SUB_OP : 16'($urandom), 1'($urandom_range(0, 1)));
      end
      4: send_half({1'b1, 15'($urandom)}, 1'b1);
      default: send_half(16'($urandom), 1'b1);
    endcase
  endtask

  initial begin
    int scans;
    int base;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = REQ_START;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_half(PUSH_MATCH, 1'b1);
    start_scan();
    send_half(16'h207f, 1'b1);
    send_half(16'h2f7f, 1'b1);
    send_half(16'h4f80, 1'b1);
    send_half(ADD3_OP, 1'b1);
    send_half(16'h8000, 1'b0);
    send_half(16'h237f, 1'b1);
    send_half(16'h237f, 1'b1);
    send_half(MVFP_OP, 1'b1);
    start_scan();
    send_half(16'he480, 1'b1);
    send_half(16'h0000, 1'b0);
    send_half(SUB_OP, 1'b0);
    start_scan();
    send_half(16'h4f7f, 1'b1);
    start_scan();
    send_half(16'he47f, 1'b1);
    send_half(16'hffff, 1'b1);
    send_half(16'hffff, 1'b1);
    start_scan();
    send_half(16'h207f, 1'b0);
    start_scan();
    send_half(16'h9000, 1'b1);
    start_scan();
    send_half(ADD3_OP, 1'b1);
    send_half(16'h7fff, 1'b1);
    send_half(16'h0000, 1'b1);
    wait_for_slots();

    base  = beats_sent;
    scans = 0;
    while (beats_sent - base < RANDOM_BEATS) begin
      if (scans == 3) hold_asks++;
      if (scans == 9) wait_for_slots();
      random_scan();
      scans++;
    end

    wait_for_slots();
    repeat (40) @(negedge clk);
    if (fail_count == 0 && slots_owed == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

/* files.f */
src/pfs_pkg.sv
src/pfs_datapath.sv
src/pfs_ctrl.sv
src/prologue_frame_size_scanner.sv
sim/pfs_slot_checker.sv
sim/prologue_frame_size_scanner_tb.sv
